@@ hw/rtl/xptw_pkg.sv @@
package xptw_pkg;

	localparam int unsigned VaWidth    = 57;
	localparam int unsigned EntryWidth = 64;
	localparam int unsigned PaWidth    = 52;
	localparam int unsigned LevelWidth = 3;
	localparam int unsigned CfgIdxWidth = 2;

	// entry bit positions
	localparam int unsigned BitP  = 0;
	localparam int unsigned BitRw = 1;
	localparam int unsigned BitUs = 2;
	localparam int unsigned BitPs = 7;
	localparam int unsigned BitNx = 63;

	typedef enum logic {
		CMD_TRANSLATE = 1'b0,
		CMD_READ_RSP  = 1'b1
	} command_t;

	typedef enum logic [1:0] {
		KIND_READ_REQ = 2'd0,
		KIND_DONE     = 2'd1,
		KIND_REJECT   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PAGE_4K = 2'd0,
		PAGE_2M = 2'd1,
		PAGE_1G = 2'd2
	} page_size_t;

	typedef enum logic [LevelWidth-1:0] {
		LVL_NONE = 3'd0,
		LVL_1    = 3'd1,
		LVL_2    = 3'd2,
		LVL_3    = 3'd3,
		LVL_4    = 3'd4,
		LVL_5    = 3'd5
	} level_t;

	localparam logic [CfgIdxWidth-1:0] CFG_TABLE_ROOT  = 2'd0;
	localparam logic [CfgIdxWidth-1:0] CFG_FIVE_LEVEL  = 2'd1;

	typedef struct packed {
		logic                  command;
		logic [VaWidth-1:0]    virtual_address;
		logic [EntryWidth-1:0] read_data;
	} item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [PaWidth-1:0] read_address;
		logic [PaWidth-1:0] frame_address;
		logic [1:0]         page_size;
		logic               fault;
		logic               present;
		logic               writable;
		logic               executable;
		logic               user;
	} result_t;

	typedef struct packed {
		logic               busy;
		level_t             level;
		logic [VaWidth-1:0] held_address;
	} walk_state_t;

	// 9-bit table index for a level
	function automatic logic [8:0] table_index(logic [VaWidth-1:0] va, level_t level);
		logic [8:0] idx;
		case (level)
			LVL_5:   idx = va[56:48];
			LVL_4:   idx = va[47:39];
			LVL_3:   idx = va[38:30];
			LVL_2:   idx = va[29:21];
			default: idx = va[20:12];
		endcase
		return idx;
	endfunction

	// table base is 4 KiB aligned, so base + idx*8 is a plain concatenation
	function automatic logic [PaWidth-1:0] entry_address(logic [PaWidth-1:0] base,
			logic [VaWidth-1:0] va, level_t level);
		return {base[PaWidth-1:12], table_index(va, level), 3'b000};
	endfunction

endpackage

@@ hw/rtl/xptw_step.sv @@
module xptw_step (
	input  xptw_pkg::item_t       item,
	input  xptw_pkg::walk_state_t cur,
	input  logic [xptw_pkg::PaWidth-1:0] table_root,
	input  logic                  five_level_enable,
	output xptw_pkg::result_t     result,
	output xptw_pkg::walk_state_t nxt
);

	logic [xptw_pkg::EntryWidth-1:0] entry;
	xptw_pkg::level_t                start_level;
	xptw_pkg::level_t                down_level;
	logic                            is_leaf_1g;
	logic                            is_leaf_2m;
	logic                            is_leaf_4k;

	assign entry       = item.read_data;
	assign start_level = five_level_enable ? xptw_pkg::LVL_5 : xptw_pkg::LVL_4;
	assign down_level  = xptw_pkg::level_t'(cur.level - 3'd1);
	assign is_leaf_1g  = (cur.level == xptw_pkg::LVL_3) && entry[xptw_pkg::BitPs];
	assign is_leaf_2m  = (cur.level == xptw_pkg::LVL_2) && entry[xptw_pkg::BitPs];
	assign is_leaf_4k  = (cur.level <= xptw_pkg::LVL_1) || (cur.level > xptw_pkg::LVL_5);

	always_comb begin
		result = '0;
		nxt    = cur;
		if (item.command == xptw_pkg::CMD_TRANSLATE) begin
			if (cur.busy) begin
				result.kind = xptw_pkg::KIND_REJECT;
			end else begin
				nxt.busy         = 1'b1;
				nxt.level        = start_level;
				nxt.held_address = item.virtual_address;
				result.kind         = xptw_pkg::KIND_READ_REQ;
				result.read_address = xptw_pkg::entry_address(table_root,
					item.virtual_address, start_level);
			end
		end else if (!cur.busy) begin
			result.kind = xptw_pkg::KIND_REJECT;
		end else if (!entry[xptw_pkg::BitP]) begin
			result.kind  = xptw_pkg::KIND_DONE;
			result.fault = 1'b1;
			nxt.busy     = 1'b0;
			nxt.level    = xptw_pkg::LVL_NONE;
		end else if (is_leaf_1g || is_leaf_2m || is_leaf_4k) begin
			result.kind          = xptw_pkg::KIND_DONE;
			result.frame_address = {entry[xptw_pkg::PaWidth-1:12], 12'h000};
			if (is_leaf_1g)
				result.page_size = xptw_pkg::PAGE_1G;
			else if (is_leaf_2m)
				result.page_size = xptw_pkg::PAGE_2M;
			else
				result.page_size = xptw_pkg::PAGE_4K;
			result.present    = entry[xptw_pkg::BitP];
			result.writable   = entry[xptw_pkg::BitRw];
			result.executable = ~entry[xptw_pkg::BitNx];
			result.user       = entry[xptw_pkg::BitUs];
			nxt.busy  = 1'b0;
			nxt.level = xptw_pkg::LVL_NONE;
		end else begin
			nxt.level           = down_level;
			result.kind         = xptw_pkg::KIND_READ_REQ;
			result.read_address = xptw_pkg::entry_address(entry[xptw_pkg::PaWidth-1:0],
				cur.held_address, down_level);
		end
	end

endmodule

@@ hw/rtl/x86_page_table_walker.sv @@
// An accepted item lands in the input register; its result moves into the result register
// once that register is free; one word per item.
// Throughput: one item per cycle unless result_stall holds the result register; the walk
// step is a single pass of bit tests and index selection between the two registers.
// Reset (arst_n low): idle, not busy, walk level and held address zero,
// table_root zero, four-level mode; both pipeline registers empty.
module x86_page_table_walker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [xptw_pkg::CfgIdxWidth-1:0]  cfg_index,
	input  logic [xptw_pkg::PaWidth-1:0]      cfg_data,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  xptw_pkg::item_t                   item,
	output logic                              result_valid,
	input  logic                              result_stall,
	output xptw_pkg::result_t                 result
);

	logic                          item_valid_s1;
	xptw_pkg::item_t               item_s1;
	logic                          result_valid_s2;
	xptw_pkg::result_t             result_s2;
	logic [xptw_pkg::PaWidth-1:0]  table_root_q;
	logic                          five_level_q;
	xptw_pkg::walk_state_t         state_q;
	xptw_pkg::walk_state_t         state_nxt;
	xptw_pkg::result_t             step_result;
	logic                          out_free;
	logic                          fire_s1;
	logic                          load_s1;

	// result register frees when empty or its word is taken this cycle
	assign out_free   = !result_valid_s2 || !result_stall;
	assign fire_s1    = item_valid_s1 && out_free;
	assign load_s1    = !item_valid_s1 || out_free;
	assign item_stall = !load_s1;
	assign cfg_ready  = 1'b1;

	assign result_valid = result_valid_s2;
	assign result       = result_s2;

	xptw_step u_step (
		.item              (item_s1),
		.cur               (state_q),
		.table_root        (table_root_q),
		.five_level_enable (five_level_q),
		.result            (step_result),
		.nxt               (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_root_q <= '0;
			five_level_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				xptw_pkg::CFG_TABLE_ROOT: table_root_q <= cfg_data;
				xptw_pkg::CFG_FIVE_LEVEL: five_level_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1   <= 1'b0;
			result_valid_s2 <= 1'b0;
			state_q         <= '{busy: 1'b0, level: xptw_pkg::LVL_NONE, held_address: '0};
		end else begin
			if (load_s1)
				item_valid_s1 <= item_valid;
			if (out_free)
				result_valid_s2 <= item_valid_s1;
			if (fire_s1)
				state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && item_valid)
			item_s1 <= item;
		if (fire_s1)
			result_s2 <= step_result;
	end

endmodule

@@ tb/tb_x86_page_table_walker.sv @@
`timescale 1ns / 1ps

module tb_x86_page_table_walker;
	import xptw_pkg::*;

	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES = 80;
	localparam logic [CfgIdxWidth-1:0] CFG_UNUSED = 2'd3;
	localparam logic [63:0] ALL_ONES = '1;

	typedef struct {
		result_t r;
		time     stamp;
	} reply_due_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIdxWidth-1:0] cfg_index = '0;
	logic [PaWidth-1:0] cfg_data = '0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;

	// walker state as the testbench sees it
	logic [PaWidth-1:0] cfg_root = '0;
	logic cfg_five = 1'b0;
	logic walk_busy = 1'b0;
	level_t walk_lvl = LVL_NONE;
	logic [VaWidth-1:0] held_va = '0;

	reply_due_t replies_due[$];

	bit idle_en = 1'b1;
	logic hold_req = 1'b0;
	int hold_left = 0;
	int burst_left = 0;
	int unsigned quiet_cycles = 0;
	int mismatches = 0;
	int n_items = 0, n_replies = 0, n_cfg_writes = 0;
	int n_4k = 0, n_2m = 0, n_1g = 0, n_faults = 0, n_rejects = 0;

	x86_page_table_walker u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [PaWidth-1:0] pte_addr(logic [PaWidth-1:0] base,
			logic [VaWidth-1:0] va, level_t lvl);
		int unsigned sh;
		logic [8:0] idx;
		sh = 12 + 9 * (int'(lvl) - 1);
		idx = va[sh +: 9];
		return {base[PaWidth-1:12], 12'h000} + {idx, 3'b000};
	endfunction

	function automatic void end_walk(ref result_t r, input logic [63:0] pte,
			input page_size_t size);
		r.kind = KIND_DONE;
		r.frame_address = {pte[51:12], 12'h000};
		r.page_size = size;
		r.present = pte[BitP];
		r.writable = pte[BitRw];
		r.executable = ~pte[BitNx];
		r.user = pte[BitUs];
		walk_busy = 1'b0;
		walk_lvl = LVL_NONE;
		case (size)
			PAGE_4K: n_4k++;
			PAGE_2M: n_2m++;
			default: n_1g++;
		endcase
	endfunction

	task automatic walk_step(input item_t it, output result_t r);
		logic [63:0] pte;
		r = '0;
		pte = it.read_data;
		if (it.command == CMD_TRANSLATE) begin
			if (walk_busy) begin
				r.kind = KIND_REJECT;
				n_rejects++;
			end else begin
				held_va = it.virtual_address;
				walk_lvl = cfg_five ? LVL_5 : LVL_4;
				walk_busy = 1'b1;
				r.kind = KIND_READ_REQ;
				r.read_address = pte_addr(cfg_root, held_va, walk_lvl);
			end
		end else if (!walk_busy) begin
			r.kind = KIND_REJECT;
			n_rejects++;
		end else if (!pte[BitP]) begin
			r.kind = KIND_DONE;
			r.fault = 1'b1;
			walk_busy = 1'b0;
			walk_lvl = LVL_NONE;
			n_faults++;
		end else if (walk_lvl == LVL_3 && pte[BitPs]) begin
			end_walk(r, pte, PAGE_1G);
		end else if (walk_lvl == LVL_2 && pte[BitPs]) begin
			end_walk(r, pte, PAGE_2M);
		end else if (walk_lvl == LVL_1) begin
			end_walk(r, pte, PAGE_4K);
		end else begin
			walk_lvl = level_t'(walk_lvl - 1);
			r.kind = KIND_READ_REQ;
			r.read_address = pte_addr(pte[PaWidth-1:0], held_va, walk_lvl);
		end
	endtask

	function automatic item_t translate_item(logic [VaWidth-1:0] va);
		item_t it;
		it = '0;
		it.command = CMD_TRANSLATE;
		it.virtual_address = va;
		return it;
	endfunction

	function automatic item_t response_item(logic [63:0] pte);
		item_t it;
		it = '0;
		it.command = CMD_READ_RSP;
		it.read_data = pte;
		return it;
	endfunction

	// mostly walks that run to the end; a few stray words and absent entries
	function automatic item_t next_item();
		logic [63:0] d;
		logic [63:0] va;
		d = {$urandom, $urandom};
		va = {$urandom, $urandom};
		if (!walk_busy) begin
			if ($urandom_range(0, 11) == 0)
				return response_item(d);
			return translate_item(va[VaWidth-1:0]);
		end
		if ($urandom_range(0, 11) == 0)
			return translate_item(va[VaWidth-1:0]);
		d[BitP] = ($urandom_range(0, 7) != 0);
		return response_item(d);
	endfunction

	task automatic send_item(input item_t it);
		result_t r;
		int gap;
		if (idle_en && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			gap = $urandom_range(1, 3);
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		walk_step(it, r);
		replies_due.push_back('{r: r, stamp: $time});
		n_items++;
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [PaWidth-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_TABLE_ROOT)
			cfg_root = val;
		else if (idx == CFG_FIVE_LEVEL)
			cfg_five = val[0];
		n_cfg_writes++;
	endtask

	task automatic test_directed();
		// reset configuration: root zero, four levels
		send_item(response_item(ALL_ONES));                 // response while idle
		send_item(translate_item('1));
		send_item(translate_item('0));                      // request while busy
		send_item(response_item(ALL_ONES));                 // PS ignored at level 4
		send_item(response_item(64'h8000_0fed_cba9_8087));  // 1 GiB, NX set
		send_item(translate_item('0));
		send_item(response_item(64'hffff_ffff_ffff_fffe)); // upper entry absent
		send_item(translate_item(57'h0ab_cdef_0123_4567));
		send_item(response_item(64'h0000_0000_1234_5003));
		send_item(response_item(64'h0000_0000_2345_6001));
		send_item(response_item(64'h7ff0_0000_3456_7087));  // 2 MiB
		send_item(translate_item('1));
		send_item(response_item(64'h000f_ffff_ffff_f001));
		send_item(response_item(64'hffff_ffff_ffff_ff7f));
		send_item(response_item(64'hffff_ffff_ffff_ff7f));
		send_item(response_item(ALL_ONES));                 // leaf, PS ignored
		send_item(translate_item(57'h155_5555_5555_5555));
		send_item(response_item(64'h0000_0000_0000_0003));
		send_item(response_item(64'h0000_0000_0000_1001));
		send_item(response_item(64'h0000_0000_0000_2001));
		send_item(response_item(64'hffff_ffff_ffff_fffe)); // leaf absent
		wait_drained();
		write_reg(CFG_FIVE_LEVEL, 52'h1);
		write_reg(CFG_TABLE_ROOT, '1);                      // low 12 bits dropped
		write_reg(CFG_UNUSED, '1);
		send_item(translate_item('1));
		send_item(response_item(ALL_ONES));                 // PS ignored at level 5
		send_item(response_item(64'h0000_0000_0000_0081));
		send_item(response_item(64'h8000_0000_0000_0086)); // level 3 absent
		wait_drained();
	endtask

	task automatic test_random_walks(input int count);
		repeat (count) send_item(next_item());
	endtask

	task automatic test_config_sweep();
		logic [PaWidth-1:0] root;
		logic [PaWidth-1:0] mode;
		for (int ph = 0; ph < 4; ph++) begin
			root = PaWidth'({$urandom, $urandom});
			mode = PaWidth'({$urandom, $urandom});
			if (ph == 1)
				root = '1;
			else if (ph == 3)
				root = '0;
			mode[0] = ph[0];
			wait_drained();
			write_reg(CFG_TABLE_ROOT, root);
			write_reg(CFG_FIVE_LEVEL, mode);
			test_random_walks(70);
		end
		wait_drained();
	endtask

	// sink holds off while words keep coming, so the walker backs up
	task automatic test_result_backpressure();
		hold_req <= 1'b1;
		test_random_walks(20);
		wait_drained();
	endtask

	task automatic test_sender_pause();
		test_random_walks(12);
		wait_drained();
		test_random_walks(12);
	endtask

	task automatic test_steady_stream();
		idle_en = 1'b0;
		test_random_walks(60);
	endtask

	always @(posedge clk) begin
		if (hold_req) begin
			hold_req <= 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left--;
		end else if (burst_left > 0) begin
			result_stall <= 1'b1;
			burst_left--;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			result_stall <= 1'b1;
			burst_left = $urandom_range(0, 2);
		end else begin
			result_stall <= 1'b0;
		end
	end

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : reply_check
		reply_due_t w;
		if (arst_n && result_valid && !result_stall) begin
			// a word pushed on this very edge cannot be the one leaving
			if (replies_due.size() == 0 || replies_due[0].stamp == $time) begin
				mismatches++;
				$display("%0t: unexpected result word, kind %0d", $time, result.kind);
			end else begin
				w = replies_due.pop_front();
				check_field("kind", w.r.kind, result.kind);
				check_field("read_address", w.r.read_address, result.read_address);
				check_field("frame_address", w.r.frame_address, result.frame_address);
				check_field("page_size", w.r.page_size, result.page_size);
				check_field("fault", w.r.fault, result.fault);
				check_field("present", w.r.present, result.present);
				check_field("writable", w.r.writable, result.writable);
				check_field("executable", w.r.executable, result.executable);
				check_field("user", w.r.user, result.user);
				n_replies++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("%0t: watchdog, nothing accepted for %0d cycles", $time, QUIET_LIMIT);
			$display("** x86_page_table_walker: FAILED **");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_sweep();
		test_result_backpressure();
		test_sender_pause();
		test_steady_stream();
		wait_drained();
		repeat (8) @(posedge clk);
		$display("Run: %0d items, %0d result words, %0d register writes, four and five levels.",
			n_items, n_replies, n_cfg_writes);
		$display("Walks: %0d to 4 KiB, %0d to 2 MiB, %0d to 1 GiB, %0d faults, %0d rejected.",
			n_4k, n_2m, n_1g, n_faults, n_rejects);
		if (mismatches == 0 && replies_due.size() == 0) begin
			$display("** x86_page_table_walker: PASSED **");
		end else begin
			$display("%0d mismatches, %0d words still due", mismatches, replies_due.size());
			$display("** x86_page_table_walker: FAILED **");
		end
		$finish;
	end

endmodule
